@@ design/aaer_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aaer_pkg
// Shared sizes, codes and control structs of the edge removal check.
// ----------------------------------------------------------------------------
package aaer_pkg;

  localparam int MAX_NODES = 512;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int LINK_W    = EDGE_W + 1;
  localparam int FIELD_W   = 10;
  localparam int LOADED_W  = EDGE_W + 1;

  localparam logic [LINK_W-1:0] NO_EDGE = LINK_W'(MAX_EDGES);

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GRAY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic              load;
    logic              analyze;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] tgt;
    logic [EDGE_W-1:0] idx;
    logic [CNT_W-1:0]  n;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic answer;
  } eng_stat_t;

endpackage
`default_nettype wire

@@ design/aaer_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aaer_if
// Valid/ready channels for edge words, result words and configuration.
// ----------------------------------------------------------------------------
interface aaer_edge_if import aaer_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               edge_valid;
  logic [FIELD_W-1:0] source_node;
  logic [FIELD_W-1:0] target_node;
  logic               last_edge;
  modport source (output valid, edge_valid, source_node, target_node, last_edge,
                  input ready);
  modport sink (input valid, edge_valid, source_node, target_node, last_edge,
                output ready);
endinterface

interface aaer_result_if;
  logic       valid;
  logic       ready;
  logic       can_be_acyclic;
  logic [1:0] status;
  modport source (output valid, can_be_acyclic, status, input ready);
  modport sink (input valid, can_be_acyclic, status, output ready);
endinterface

interface aaer_cfg_if import aaer_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface
`default_nettype wire

@@ design/aaer_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aaer_engine
// Graph store and depth-first walk sequencer with an explicit stack.
// ----------------------------------------------------------------------------
module aaer_engine import aaer_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire eng_cmd_t  cmd,
  output eng_stat_t      stat
);

  typedef enum logic [4:0] {
    S_CLR_HEAD, S_IDLE, S_LOAD, S_CLR_COL, S_ROOT, S_ROOT_CHK, S_ROOT_PUSH,
    S_STEP, S_POP_RD, S_POP_NX, S_EDGE, S_EDGE_COL, S_PUSH, S_REC_RD,
    S_REC_CMP, S_CPY_RD, S_CPY_WR, S_TRY, S_TRY_E, S_TRY_SET, S_FINISH
  } state_t;

  state_t state;

  logic [LINK_W-1:0] head_mem [MAX_NODES];
  logic [NODE_W-1:0] esrc_mem [MAX_EDGES];
  logic [NODE_W-1:0] etgt_mem [MAX_EDGES];
  logic [LINK_W-1:0] enxt_mem [MAX_EDGES];
  logic [1:0]        color_mem [MAX_NODES];
  logic [NODE_W-1:0] snode_mem [MAX_NODES];
  logic [LINK_W-1:0] sedge_mem [MAX_NODES];
  logic [EDGE_W-1:0] cyc_mem [MAX_NODES];

  logic [NODE_W-1:0] h_raddr, h_waddr;
  logic              h_we;
  logic [LINK_W-1:0] h_wdata, h_q;
  logic [EDGE_W-1:0] e_raddr, e_waddr;
  logic              e_we;
  logic [NODE_W-1:0] e_wsrc, e_wtgt, e_src_q, e_tgt_q;
  logic [LINK_W-1:0] e_wnxt, e_nxt_q;
  logic [NODE_W-1:0] c_raddr, c_waddr;
  logic              c_we;
  logic [1:0]        c_wdata, col_q;
  logic [NODE_W-1:0] s_raddr, s_waddr, s_wnode, sn_q;
  logic              s_we;
  logic [LINK_W-1:0] s_wedge, se_q;
  logic [NODE_W-1:0] y_raddr, y_waddr;
  logic              y_we;
  logic [EDGE_W-1:0] y_wdata, y_q;

  logic [CNT_W-1:0]  n, cnt, root, sp, k, clen, c;
  logic [NODE_W-1:0] cur_v, t, xs, xt, ld_src, ld_tgt;
  logic [LINK_W-1:0] cur_e, nx;
  logic [EDGE_W-1:0] ld_idx;
  logic              skip, excl, record, trying, answer, ana_pend;

  logic [CNT_W-1:0] sp_m1, sp_m2;
  logic             found, push_ok;

  assign sp_m1   = sp - CNT_W'(1);
  assign sp_m2   = sp - CNT_W'(2);
  assign found   = !skip && (col_q == COLOR_GRAY);
  assign push_ok = !skip && (col_q == COLOR_WHITE) && (sp < CNT_W'(MAX_NODES));

  always_comb begin
    h_raddr = '0; h_we = 1'b0; h_waddr = '0; h_wdata = NO_EDGE;
    e_raddr = '0; e_we = 1'b0; e_waddr = '0;
    e_wsrc = '0; e_wtgt = '0; e_wnxt = NO_EDGE;
    c_raddr = '0; c_we = 1'b0; c_waddr = '0; c_wdata = COLOR_WHITE;
    s_raddr = '0; s_we = 1'b0; s_waddr = '0; s_wnode = '0; s_wedge = NO_EDGE;
    y_raddr = '0; y_we = 1'b0; y_waddr = '0; y_wdata = '0;
    case (state)
      S_CLR_HEAD: begin
        h_we = 1'b1; h_waddr = cnt[NODE_W-1:0]; h_wdata = NO_EDGE;
      end
      S_IDLE: h_raddr = cmd.src;
      S_LOAD: begin
        e_we = 1'b1; e_waddr = ld_idx; e_wsrc = ld_src; e_wtgt = ld_tgt; e_wnxt = h_q;
        h_we = 1'b1; h_waddr = ld_src; h_wdata = {1'b0, ld_idx};
      end
      S_CLR_COL: begin
        c_we = 1'b1; c_waddr = cnt[NODE_W-1:0]; c_wdata = COLOR_WHITE;
      end
      S_ROOT: c_raddr = root[NODE_W-1:0];
      S_ROOT_CHK: begin
        c_we = (col_q == COLOR_WHITE); c_waddr = root[NODE_W-1:0]; c_wdata = COLOR_GRAY;
        h_raddr = root[NODE_W-1:0];
      end
      S_ROOT_PUSH: begin
        s_we = 1'b1; s_waddr = '0; s_wnode = root[NODE_W-1:0]; s_wedge = h_q;
      end
      S_STEP: begin
        if (cur_e >= NO_EDGE) begin
          c_we = 1'b1; c_waddr = cur_v; c_wdata = COLOR_BLACK;
          s_raddr = sp_m2[NODE_W-1:0];
        end else begin
          e_raddr = cur_e[EDGE_W-1:0];
        end
      end
      S_POP_RD: begin
        if (se_q < NO_EDGE) begin
          e_raddr = se_q[EDGE_W-1:0];
        end else begin
          s_we = 1'b1; s_waddr = sp_m1[NODE_W-1:0]; s_wnode = sn_q; s_wedge = NO_EDGE;
        end
      end
      S_POP_NX: begin
        s_we = 1'b1; s_waddr = sp_m1[NODE_W-1:0]; s_wnode = cur_v; s_wedge = e_nxt_q;
      end
      S_EDGE: c_raddr = e_tgt_q;
      S_EDGE_COL: begin
        if (push_ok) begin
          c_we = 1'b1; c_waddr = t; c_wdata = COLOR_GRAY;
          h_raddr = t;
        end else if (!found) begin
          s_we = 1'b1; s_waddr = sp_m1[NODE_W-1:0]; s_wnode = cur_v; s_wedge = nx;
        end
      end
      S_PUSH: begin
        s_we = 1'b1; s_waddr = sp[NODE_W-1:0]; s_wnode = t; s_wedge = h_q;
      end
      S_REC_RD: s_raddr = k[NODE_W-1:0];
      S_CPY_RD: s_raddr = k[NODE_W-1:0];
      S_CPY_WR: begin
        y_we = 1'b1; y_waddr = clen[NODE_W-1:0]; y_wdata = se_q[EDGE_W-1:0];
      end
      S_TRY:   y_raddr = c[NODE_W-1:0];
      S_TRY_E: e_raddr = y_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) head_mem[h_waddr] <= h_wdata;
    h_q <= head_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      esrc_mem[e_waddr] <= e_wsrc;
      etgt_mem[e_waddr] <= e_wtgt;
      enxt_mem[e_waddr] <= e_wnxt;
    end
    e_src_q <= esrc_mem[e_raddr];
    e_tgt_q <= etgt_mem[e_raddr];
    e_nxt_q <= enxt_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) color_mem[c_waddr] <= c_wdata;
    col_q <= color_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      snode_mem[s_waddr] <= s_wnode;
      sedge_mem[s_waddr] <= s_wedge;
    end
    sn_q <= snode_mem[s_raddr];
    se_q <= sedge_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (y_we) cyc_mem[y_waddr] <= y_wdata;
    y_q <= cyc_mem[y_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR_HEAD;
      cnt      <= '0;
      ana_pend <= 1'b0;
      trying   <= 1'b0;
      answer   <= 1'b0;
    end else begin
      case (state)
        S_CLR_HEAD: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          n <= cmd.n;
          excl <= 1'b0; record <= 1'b1; trying <= 1'b0; cnt <= '0;
          if (cmd.load) begin
            ld_src <= cmd.src; ld_tgt <= cmd.tgt; ld_idx <= cmd.idx;
            ana_pend <= cmd.analyze;
            state <= S_LOAD;
          end else if (cmd.analyze) begin
            state <= S_CLR_COL;
          end
        end
        S_LOAD: begin
          state <= ana_pend ? S_CLR_COL : S_IDLE;
          ana_pend <= 1'b0;
        end
        S_CLR_COL: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == n - CNT_W'(1)) begin
            root <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root == n) begin
            if (trying) begin
              answer <= 1'b1; state <= S_FINISH;
            end else begin
              answer <= 1'b1; state <= S_FINISH;
            end
          end else begin
            state <= S_ROOT_CHK;
          end
        end
        S_ROOT_CHK: begin
          if (col_q == COLOR_WHITE) begin
            state <= S_ROOT_PUSH;
          end else begin
            root <= root + CNT_W'(1);
            state <= S_ROOT;
          end
        end
        S_ROOT_PUSH: begin
          cur_v <= root[NODE_W-1:0];
          cur_e <= h_q;
          sp    <= CNT_W'(1);
          state <= S_STEP;
        end
        S_STEP: begin
          if (cur_e >= NO_EDGE) begin
            sp <= sp_m1;
            if (sp == CNT_W'(1)) begin
              root <= root + CNT_W'(1);
              state <= S_ROOT;
            end else begin
              state <= S_POP_RD;
            end
          end else begin
            state <= S_EDGE;
          end
        end
        S_POP_RD: begin
          cur_v <= sn_q;
          if (se_q < NO_EDGE) begin
            state <= S_POP_NX;
          end else begin
            cur_e <= NO_EDGE;
            state <= S_STEP;
          end
        end
        S_POP_NX: begin
          cur_e <= e_nxt_q;
          state <= S_STEP;
        end
        S_EDGE: begin
          t    <= e_tgt_q;
          nx   <= e_nxt_q;
          skip <= ({1'b0, e_tgt_q} >= n) || ({1'b0, e_src_q} >= n) ||
                  (excl && (e_src_q == xs) && (e_tgt_q == xt));
          state <= S_EDGE_COL;
        end
        S_EDGE_COL: begin
          if (found) begin
            if (record) begin
              k <= '0;
              state <= S_REC_RD;
            end else begin
              c <= c + CNT_W'(1);
              state <= S_TRY;
            end
          end else if (push_ok) begin
            state <= S_PUSH;
          end else begin
            cur_e <= nx;
            state <= S_STEP;
          end
        end
        S_PUSH: begin
          cur_v <= t;
          cur_e <= h_q;
          sp    <= sp + CNT_W'(1);
          state <= S_STEP;
        end
        S_REC_RD: state <= S_REC_CMP;
        S_REC_CMP: begin
          if (sn_q == t) begin
            clen <= '0;
            state <= S_CPY_RD;
          end else begin
            k <= k + CNT_W'(1);
            state <= S_REC_RD;
          end
        end
        S_CPY_RD: state <= S_CPY_WR;
        S_CPY_WR: begin
          clen <= clen + CNT_W'(1);
          k    <= k + CNT_W'(1);
          if (k + CNT_W'(1) == sp) begin
            c <= '0;
            state <= S_TRY;
          end else begin
            state <= S_CPY_RD;
          end
        end
        S_TRY: begin
          if (c == clen) begin
            answer <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_TRY_E;
          end
        end
        S_TRY_E: state <= S_TRY_SET;
        S_TRY_SET: begin
          xs <= e_src_q; xt <= e_tgt_q;
          excl <= 1'b1; record <= 1'b0; trying <= 1'b1;
          cnt <= '0;
          state <= S_CLR_COL;
        end
        S_FINISH: begin
          cnt <= '0;
          state <= S_CLR_HEAD;
        end
        default: state <= S_CLR_HEAD;
      endcase
    end
  end

  assign stat.busy   = (state != S_IDLE);
  assign stat.done   = (state == S_FINISH);
  assign stat.answer = answer;

endmodule
`default_nettype wire

@@ design/almost_acyclic_edge_removal_check.sv @@
`default_nettype none
// A last edge word starts up to 1 + L walks (L = recorded cycle length); each
// walk clears the marks of n nodes, then scans roots, visits edges and pushes
// and pops nodes. A stored edge word holds input off while it is written.
// After each result and after reset all 512 node list heads are cleared with
// input held off.
// ----------------------------------------------------------------------------
// almost_acyclic_edge_removal_check
// Top level: edge intake, error flags, configuration and result register.
// ----------------------------------------------------------------------------
module almost_acyclic_edge_removal_check import aaer_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  aaer_edge_if.sink   edges,
  aaer_result_if.source results,
  aaer_cfg_if.sink    cfg
);

  logic [FIELD_W-1:0]  node_count;
  logic [LOADED_W-1:0] loaded;
  logic                flag_range, flag_ovf, pend, out_valid, out_answer;
  logic [1:0]          out_status;

  logic [CNT_W-1:0] n;
  logic             in_acc, bad, full, store;
  eng_cmd_t         cmd;
  eng_stat_t        stat;

  assign n = (node_count == '0) ? CNT_W'(1) :
             (node_count > FIELD_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
             CNT_W'(node_count);

  assign edges.ready = !stat.busy && !pend && !out_valid;
  assign in_acc = edges.valid && edges.ready;
  assign bad = (edges.source_node == '0) || (CNT_W'(edges.source_node) > n) ||
               (edges.target_node == '0) || (CNT_W'(edges.target_node) > n);
  assign full  = (loaded >= LOADED_W'(MAX_EDGES));
  assign store = in_acc && edges.edge_valid && !bad && !full;

  assign cmd.load    = store;
  assign cmd.analyze = in_acc && edges.last_edge;
  assign cmd.src     = NODE_W'(edges.source_node - FIELD_W'(1));
  assign cmd.tgt     = NODE_W'(edges.target_node - FIELD_W'(1));
  assign cmd.idx     = loaded[EDGE_W-1:0];
  assign cmd.n       = n;

  aaer_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= FIELD_W'(MAX_NODES);
      loaded     <= '0;
      flag_range <= 1'b0;
      flag_ovf   <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) node_count <= cfg.node_count;
      if (in_acc && edges.edge_valid) begin
        if (bad) flag_range <= 1'b1;
        else if (full) flag_ovf <= 1'b1;
      end
      if (store) loaded <= loaded + LOADED_W'(1);
      if (cmd.analyze) pend <= 1'b1;
      if (out_valid && results.ready) out_valid <= 1'b0;
      if (stat.done) begin
        out_valid  <= 1'b1;
        out_answer <= stat.answer;
        out_status <= flag_range ? STATUS_RANGE :
                      (flag_ovf ? STATUS_OVERFLOW : STATUS_OK);
        flag_range <= 1'b0;
        flag_ovf   <= 1'b0;
        loaded     <= '0;
        pend       <= 1'b0;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.can_be_acyclic = out_answer;
  assign results.status         = out_status;

  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> pend) else $error("result without a pending graph");
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> results.valid) else $error("result word not raised");
  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= LOADED_W'(MAX_EDGES)) else $error("edge count past store depth");

endmodule
`default_nettype wire

@@ tb/almost_acyclic_edge_removal_check_test.sv @@
// ----------------------------------------------------------------------------
// almost_acyclic_edge_removal_check_test
// Feeds edge words for many small graphs, plus a few large and faulty ones,
// and predicts each answer and status with a depth-first cycle search of its
// own. Both channels idle at random; results are checked in order.
// ----------------------------------------------------------------------------
module almost_acyclic_edge_removal_check_test;
  import aaer_pkg::*;

  typedef struct {
    bit               has_edge;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] tgt;
    bit               last;
  } edge_word_t;

  typedef struct {
    bit         acyclic;
    logic [1:0] status;
  } verdict_t;

  logic clk = 0;
  logic rst = 1;

  aaer_edge_if   edges_ch();
  aaer_result_if results_ch();
  aaer_cfg_if    cfg_ch();

  almost_acyclic_edge_removal_check DUT (
    .clk(clk), .rst(rst), .edges(edges_ch), .results(results_ch), .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  edge_word_t edge_words[$];
  verdict_t   verdicts[$];
  edge_word_t cur_word;
  int errors = 0;
  int words_sent = 0;
  int verdicts_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic quiet = 0;
  logic hold = 0;
  logic press_go = 0;

  // graph mirror
  int node_reg = 512;
  int esrc[MAX_EDGES];
  int etgt[MAX_EDGES];
  int elink[MAX_EDGES];
  int head[MAX_NODES];
  int loaded = 0;
  logic [1:0] color[MAX_NODES];
  int stk_node[MAX_NODES];
  int stk_edge[MAX_NODES];
  int loop_edges[MAX_NODES];
  int loop_len = 0;
  bit flag_ovf = 0;
  bit flag_rng = 0;

  function automatic int live_nodes();
    if (node_reg == 0) return 1;
    if (node_reg > MAX_NODES) return MAX_NODES;
    return node_reg;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < MAX_NODES; i++) head[i] = MAX_EDGES;
    loaded = 0;
    loop_len = 0;
    flag_ovf = 0;
    flag_rng = 0;
  endfunction

  function automatic bit has_cycle(int n, bit excl, int xs, int xt, bit rec);
    int sp, v, e, t, p, pe;
    bit skip;
    for (int i = 0; i < MAX_NODES; i++) color[i] = COLOR_WHITE;
    for (int root = 0; root < n; root++) begin
      if (color[root] != COLOR_WHITE) continue;
      color[root] = COLOR_GRAY;
      stk_node[0] = root;
      stk_edge[0] = head[root];
      sp = 1;
      while (sp > 0) begin
        v = stk_node[sp-1];
        e = stk_edge[sp-1];
        if (e >= MAX_EDGES) begin
          color[v] = COLOR_BLACK;
          sp--;
          if (sp > 0) begin
            pe = stk_edge[sp-1];
            stk_edge[sp-1] = (pe < MAX_EDGES) ? elink[pe] : MAX_EDGES;
          end
          continue;
        end
        t = etgt[e];
        skip = (t >= n) || (esrc[e] >= n) || (excl && esrc[e] == xs && t == xt);
        if (!skip && color[t] == COLOR_GRAY) begin
          if (rec) begin
            p = 0;
            while (p < sp && stk_node[p] != t) p++;
            loop_len = 0;
            for (int k = p; k < sp; k++) begin
              loop_edges[loop_len] = stk_edge[k];
              loop_len++;
            end
          end
          return 1;
        end
        if (!skip && color[t] == COLOR_WHITE && sp < MAX_NODES) begin
          color[t] = COLOR_GRAY;
          stk_node[sp] = t;
          stk_edge[sp] = head[t];
          sp++;
          continue;
        end
        stk_edge[sp-1] = elink[e];
      end
    end
    return 0;
  endfunction

  function automatic void absorb_word(edge_word_t w);
    int n, e;
    verdict_t vd;
    n = live_nodes();
    if (w.has_edge) begin
      if (w.src < 1 || w.src > n || w.tgt < 1 || w.tgt > n) flag_rng = 1;
      else if (loaded >= MAX_EDGES) flag_ovf = 1;
      else begin
        e = loaded;
        loaded++;
        esrc[e] = w.src - 1;
        etgt[e] = w.tgt - 1;
        elink[e] = head[w.src - 1];
        head[w.src - 1] = e;
      end
    end
    if (!w.last) return;
    vd.acyclic = 0;
    if (!has_cycle(n, 0, 0, 0, 1)) vd.acyclic = 1;
    else begin
      for (int c = 0; c < loop_len; c++) begin
        e = loop_edges[c];
        if (!has_cycle(n, 1, esrc[e], etgt[e], 0)) begin
          vd.acyclic = 1;
          break;
        end
      end
    end
    vd.status = flag_rng ? STATUS_RANGE : (flag_ovf ? STATUS_OVERFLOW : STATUS_OK);
    verdicts.insert(verdicts.size(), vd);
    clear_graph();
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      edges_ch.valid <= 0;
    end else begin
      if (edges_ch.valid && edges_ch.ready) begin
        absorb_word(cur_word);
        words_sent++;
      end
      if (!(edges_ch.valid && !edges_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          edges_ch.valid <= 0;
        end else if (edge_words.size() > 0) begin
          cur_word = edge_words.pop_front();
          edges_ch.valid <= 1;
          edges_ch.edge_valid <= cur_word.has_edge;
          edges_ch.source_node <= cur_word.src;
          edges_ch.target_node <= cur_word.tgt;
          edges_ch.last_edge <= cur_word.last;
          if (!quiet && $urandom_range(0, 6) == 0) gap_left = $urandom_range(1, 5);
        end else begin
          edges_ch.valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        verdicts_seen++;
        if (verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: acyclic=%0b status=%0d",
                                     results_ch.can_be_acyclic, results_ch.status);
        end else begin
          verdict_t vd;
          vd = verdicts.pop_front();
          if (results_ch.can_be_acyclic !== vd.acyclic || results_ch.status !== vd.status) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected acyclic=%0b status=%0d, got acyclic=%0b status=%0d",
                       verdicts_seen, vd.acyclic, vd.status,
                       results_ch.can_be_acyclic, results_ch.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 0;
      end else begin
        results_ch.ready <= !hold;
        if (!quiet && $urandom_range(0, 8) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (press_go);
    @(posedge clk);
    hold <= 1;
    repeat (3000) @(posedge clk);
    hold <= 0;
  end

  initial begin
    #100_000_000;
    $display("almost_acyclic_edge_removal_check: mismatch");
    $finish;
  end

  task automatic push_word(bit v, int s, int t, bit l);
    edge_word_t w;
    w.has_edge = v;
    w.src = FIELD_W'(s);
    w.tgt = FIELD_W'(t);
    w.last = l;
    edge_words.insert(edge_words.size(), w);
  endtask

  task automatic drain();
    while (edge_words.size() > 0 || edges_ch.valid || verdicts.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_node_count(int v);
    @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.node_count <= FIELD_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    node_reg = v;
  endtask

  task automatic random_graph(int n);
    int cnt, s, t;
    cnt = $urandom_range(0, 14);
    for (int i = 0; i < cnt; i++) begin
      s = $urandom_range(1, n);
      t = $urandom_range(1, n);
      case ($urandom_range(0, 19))
        0: push_word(1, $urandom_range(0, 1023), t, 0);
        1: push_word(1, s, $urandom_range(0, 1023), 0);
        2: push_word(0, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        default: push_word(1, s, t, 0);
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_word(0, $urandom_range(0, 1023), 0, 1);
    else push_word(1, $urandom_range(1, n), $urandom_range(1, n), 1);
  endtask

  initial begin
    int n, graphs, phase;
    edges_ch.valid = 0;
    edges_ch.edge_valid = 0;
    edges_ch.source_node = 0;
    edges_ch.target_node = 0;
    edges_ch.last_edge = 0;
    cfg_ch.valid = 0;
    cfg_ch.node_count = 0;
    results_ch.ready = 0;
    clear_graph();
    repeat (11) @(posedge clk);
    rst <= 0;

    // empty graph, self loop, extreme nodes, bad nodes, two disjoint loops, parallel edges
    push_word(0, 0, 0, 0);
    push_word(0, 0, 0, 1);
    push_word(1, 1, 1, 1);
    push_word(1, 512, 1, 0);
    push_word(1, 1, 512, 1);
    push_word(1, 0, 5, 0);
    push_word(1, 1023, 1, 0);
    push_word(1, 3, 3, 1);
    push_word(1, 1, 2, 0);
    push_word(1, 2, 1, 0);
    push_word(1, 3, 4, 0);
    push_word(1, 4, 3, 1);
    push_word(1, 1, 2, 0);
    push_word(1, 1, 2, 0);
    push_word(1, 2, 1, 1);
    drain();
    set_node_count(0);
    push_word(1, 1, 1, 1);
    push_word(1, 1, 2, 1);
    drain();
    // lower node count after loading
    set_node_count(10);
    push_word(1, 5, 6, 0);
    push_word(1, 6, 5, 0);
    push_word(1, 1, 2, 0);
    drain();
    set_node_count(4);
    push_word(1, 2, 1, 1);
    drain();
    // bad node mixed with good edges
    set_node_count(3);
    push_word(1, 1, 2, 0);
    push_word(1, 2, 3, 0);
    push_word(1, 3, 1, 0);
    push_word(1, 4, 1, 1);
    drain();
    set_node_count(1023);
    push_word(1, 513, 1, 0);
    push_word(1, 300, 300, 1);
    drain();

    phase = 0;
    while (words_sent < 1050) begin
      case ($urandom_range(0, 19))
        0: n = 512;
        1: n = 1023;
        2: n = 0;
        3, 4: n = $urandom_range(13, 60);
        default: n = $urandom_range(1, 12);
      endcase
      set_node_count(n);
      if (n == 0) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      if (phase == 5) press_go <= 1;
      if (words_sent > 900) quiet <= 1;
      graphs = $urandom_range(1, 6);
      for (int g = 0; g < graphs; g++) random_graph(n);
      drain();
      phase++;
    end
    set_node_count(512);

    $display("covered %0d edge words and %0d verdicts over %0d random phases",
             words_sent, verdicts_seen, phase);
    if (errors == 0) $display("almost_acyclic_edge_removal_check: match");
    else $display("almost_acyclic_edge_removal_check: mismatch");
    $finish;
  end

endmodule
